>>> hdl/mvm_pkg.sv
// Shared types, constants and helpers for the matrix-vector multiply core.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package mvm_pkg;

  // Sizing
  localparam int MAX_COLS     = 256;
  localparam int ELEMENT_BITS = 16;
  localparam int ADDR_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int IDX_W        = 8;
  localparam int DIM_W        = 9;
  localparam int SUM_W        = 40;
  localparam int PROD_W       = 2 * ELEMENT_BITS;
  localparam int COL_LIMIT    = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int ROW_LIMIT    = 256;
  localparam int CFG_IDX_W    = 8;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = CFG_IDX_W'(1);

  // Input modes
  localparam logic MODE_VECTOR = 1'b0;
  localparam logic MODE_MATRIX = 1'b1;

  typedef struct packed {
    logic                           mode;
    logic signed [ELEMENT_BITS-1:0] element_value;
    logic [IDX_W-1:0]               vector_index;
  } mvm_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row_index;
    logic signed [SUM_W-1:0] dot_product;
    logic                    last_row;
  } mvm_out_t;

  // Classified word passed from front to back
  typedef struct packed {
    logic                           is_matrix;
    logic                           wr_ok;
    logic [ADDR_W-1:0]              addr;
    logic signed [ELEMENT_BITS-1:0] value;
  } mvm_op_t;

  // Effective dimensions and restart strobe
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic             restart;
  } mvm_ctl_t;

  // Zero acts as one, anything above the limit acts as the limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

>>> hdl/mvm_front.sv
// Front end: configuration registers, input acceptance and classification.
// Depends on mvm_pkg; feeds mvm_queue.
`timescale 1ns / 1ps

module mvm_front
  import mvm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mvm_in_t              in_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 q_full,
  output logic                 q_push,
  output mvm_op_t              q_op,
  output mvm_ctl_t             ctl
);

  logic [DIM_W-1:0] num_rows_r, num_rows_nxt;
  logic [DIM_W-1:0] num_cols_r, num_cols_nxt;
  logic             cfg_wr;
  logic             restart;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Register writes
  always_comb begin
    num_rows_nxt = num_rows_r;
    num_cols_nxt = num_cols_r;
    restart      = 1'b0;
    if (cfg_wr) begin
      case (cfg_index)
        CFG_NUM_ROWS: begin
          num_rows_nxt = cfg_data;
          restart      = 1'b1;
        end
        CFG_NUM_COLS: begin
          num_cols_nxt = cfg_data;
          restart      = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= DIM_W'(1);
      num_cols_r <= DIM_W'(1);
    end else begin
      num_rows_r <= num_rows_nxt;
      num_cols_r <= num_cols_nxt;
    end
  end

  // Effective dimensions plus restart strobe, in mvm_ctl_t field order
  assign ctl = {clamp_dim(num_rows_r, DIM_W'(ROW_LIMIT)),
                clamp_dim(num_cols_r, DIM_W'(COL_LIMIT)),
                restart};

  // Accept while the queue has room; classify the word
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_op.is_matrix = (in_data.mode == MODE_MATRIX);
    q_op.wr_ok     = (32'(in_data.vector_index) < MAX_COLS);
    q_op.addr      = ADDR_W'(in_data.vector_index);
    q_op.value     = in_data.element_value;
  end

endmodule

>>> hdl/mvm_queue.sv
// Short FIFO of classified words between front and back.
// Depends on mvm_pkg.
`timescale 1ns / 1ps

module mvm_queue
  import mvm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  mvm_op_t push_op,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output mvm_op_t head_op
);

  mvm_op_t              slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_op   = slot_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue read while empty");
`endif

endmodule

>>> hdl/mvm_back.sv
// Back end: vector store, column/row sequencing, multiply, accumulate, result register.
// Depends on mvm_pkg; drains mvm_queue.
`timescale 1ns / 1ps

module mvm_back
  import mvm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mvm_ctl_t ctl,
  input  logic     q_valid,
  input  mvm_op_t  q_op,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output mvm_out_t out_data
);

  logic [ELEMENT_BITS-1:0]        vec_mem [MAX_COLS];

  logic                           advance;
  logic                           issue_mat;
  logic                           issue_vec;
  logic                           col_last;
  logic                           row_last;

  logic [IDX_W-1:0]               col_cnt_r, col_cnt_nxt;
  logic [IDX_W-1:0]               row_cnt_r, row_cnt_nxt;

  // Stage 1: store read in flight
  logic                           s1_valid_r;
  logic                           s1_end_r;
  logic                           s1_last_r;
  logic                           s1_col_ok_r;
  logic [IDX_W-1:0]               s1_row_r;
  logic signed [ELEMENT_BITS-1:0] s1_value_r;
  logic [ELEMENT_BITS-1:0]        mem_rd_r;

  // Stage 2: product
  logic                           s2_valid_r;
  logic                           s2_end_r;
  logic                           s2_last_r;
  logic [IDX_W-1:0]               s2_row_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [ELEMENT_BITS-1:0] x_sel;

  // Stage 3: accumulate and result
  logic signed [SUM_W-1:0]        acc_r;
  logic signed [SUM_W-1:0]        sum;
  logic                           out_valid_r;
  mvm_out_t                       out_data_r;

  // Whole back end moves unless a result waits untaken
  assign advance   = !out_valid_r || out_ready;
  assign q_pop     = q_valid && advance;
  assign issue_mat = q_pop && q_op.is_matrix;
  assign issue_vec = q_pop && !q_op.is_matrix;

  // Column and row sequencing at issue
  assign col_last = (DIM_W'(col_cnt_r) + DIM_W'(1)) >= ctl.cols;
  assign row_last = (DIM_W'(row_cnt_r) + DIM_W'(1)) >= ctl.rows;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (ctl.restart) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (issue_mat) begin
      if (col_last) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = row_last ? '0 : row_cnt_r + IDX_W'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // Vector store: write on vector words, registered read at current column
  always_ff @(posedge clk) begin
    if (issue_vec && q_op.wr_ok) begin
      vec_mem[q_op.addr] <= q_op.value;
    end
    if (advance) begin
      mem_rd_r <= vec_mem[ADDR_W'(col_cnt_r)];
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= issue_mat;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_end_r    <= col_last;
      s1_last_r   <= row_last;
      s1_col_ok_r <= (32'(col_cnt_r) < MAX_COLS);
      s1_row_r    <= row_cnt_r;
      s1_value_r  <= q_op.value;
    end
  end

  // Stage 2: multiply; a column past the store reads as zero
  assign x_sel = s1_col_ok_r ? signed'(mem_rd_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_end_r  <= s1_end_r;
      s2_last_r <= s1_last_r;
      s2_row_r  <= s1_row_r;
      prod_r    <= PROD_W'(s1_value_r) * PROD_W'(x_sel);
    end
  end

  // Stage 3: accumulate, close the row into the result register
  assign sum = acc_r + SUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.restart) begin
        acc_r <= '0;
      end else if (advance && s2_valid_r) begin
        acc_r <= s2_end_r ? '0 : sum;
      end
      if (advance) begin
        out_valid_r <= s2_valid_r && s2_end_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid_r && s2_end_r) begin
      out_data_r.row_index   <= s2_row_r;
      out_data_r.dot_product <= sum;
      out_data_r.last_row    <= s2_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    DIM_W'(col_cnt_r) < ctl.cols) else $error("column count past row length");
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    DIM_W'(row_cnt_r) < ctl.rows) else $error("row count past matrix height");
  a_row_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s2_valid_r && s2_end_r) |=> out_valid_r)
    else $error("completed row produced no result");
`endif

endmodule

>>> hdl/matrix_vector_multiply_core.sv
// Top level of the integer matrix-vector multiply core (b = A * x).
// Depends on mvm_pkg, mvm_front, mvm_queue, mvm_back.
//
//   channel  ports                                  word
//   -------  -------------------------------------  ------------------------
//   input    in_valid / in_ready / in_data          mvm_in_t  (mode, value, index)
//   result   out_valid / out_ready / out_data       mvm_out_t (row, dot product, last)
//   config   cfg_valid / cfg_ready / cfg_index,     index 0 num_rows, 1 num_cols
//            cfg_data
//
// Throughput, while no held result stalls the back end, is one input word per
// cycle, vector or matrix, set by the single multiply-accumulate and the
// one-write/one-read port of the vector store. A matrix word is written into the
// queue, then passes the store read, multiply and accumulate registers in turn.
// Reset is synchronous, active low; the vector store is not cleared.
// A held result (out_ready low) freezes the back end; the four-word queue
// keeps in_ready high meanwhile, then in_ready drops when it fills.
`timescale 1ns / 1ps

module matrix_vector_multiply_core
  import mvm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mvm_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mvm_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     q_not_empty;
  mvm_op_t  q_in_op;
  mvm_op_t  q_head_op;
  mvm_ctl_t ctl;

  mvm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (q_in_op),
    .ctl       (ctl)
  );

  mvm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (q_in_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_op   (q_head_op)
  );

  mvm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .q_valid   (q_not_empty),
    .q_op      (q_head_op),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
